@@ rtl/wrs_pkg.sv @@
// Shared types and constants for the word reverser stack.
// No dependencies; compiled first.
package wrs_pkg;

    localparam int CHAR_W      = 8;
    localparam int STACK_DEPTH = 32;

    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PERIOD = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SP_RD,
        ST_SP_PER,
        ST_SP_COM_RD,
        ST_SP_COM,
        ST_WORD_RD,
        ST_WORD_EMIT,
        ST_TAIL,
        ST_FL_RD,
        ST_FL_CHK,
        ST_FL_EMIT_RD,
        ST_FL_EMIT,
        ST_CLOSE
    } wrs_state_t;

endpackage

@@ rtl/wrs_if.sv @@
// Valid/ready channel interfaces for the word reverser stack.
// Depends on wrs_pkg for the character width.
interface wrs_in_if import wrs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;
    logic              line_end;

    modport source (output valid, output in_char, output line_end, input ready);
    modport sink   (input valid, input in_char, input line_end, output ready);
endinterface

interface wrs_out_if import wrs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              run_last;
    logic              line_done;
    logic              overflow;

    modport source (output valid, output out_char, output run_last, output line_done,
                    output overflow, input ready);
    modport sink   (input valid, input out_char, input run_last, input line_done,
                    input overflow, output ready);
endinterface

@@ rtl/word_reverser_stack.sv @@
// Word reverser stack, top level: stack RAM plus controller.
// Depends on wrs_pkg, wrs_if, wrs_ram and wrs_ctrl.
//
// Usage:
//   char_ch takes one character per transfer with a line_end flag on the
//   last character of a line. rev_ch delivers the reversed text, one byte
//   per transfer; run_last marks the last byte caused by an input item,
//   line_done the closing period of a line, overflow that a character of
//   the line was dropped on a full stack.
//   Flow: a non-space character that does not end a line is taken while
//   idle and gives no output. A space pops and emits the stacked word,
//   then its tail; a line end flushes the remaining characters and
//   closes with a period. Every pop waits on the registered read of the
//   stack RAM in a *_RD state; the flush also passes through the period
//   check in ST_FL_CHK. char_ch is ready only between items.
//   Reset clears the stack pointer, the overflow flag and the output valid
//   bit; the payload and the RAM contents are not cleared and need not be.
//   A stalled receiver holds the current byte in the output register and
//   the controller waits on its next emission without losing state.
module word_reverser_stack import wrs_pkg::*; #(
    parameter int DEPTH = STACK_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    wrs_in_if.sink    char_ch,
    wrs_out_if.source rev_ch
);

    localparam int AW = $clog2(DEPTH);

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    wrs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_ch   (char_ch),
        .rev_ch    (rev_ch),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    wrs_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

@@ rtl/wrs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/wrs_ctrl.sv @@
// Stack controller: push/pop sequencing, punctuation handling, output register.
// Depends on wrs_pkg and the wrs_in_if / wrs_out_if interfaces.
module wrs_ctrl import wrs_pkg::*; #(
    parameter int DEPTH = STACK_DEPTH,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    wrs_in_if.sink            char_ch,
    wrs_out_if.source         rev_ch,
    output logic              ram_we,
    output logic [AW-1:0]     ram_waddr,
    output logic [CHAR_W-1:0] ram_wdata,
    output logic [AW-1:0]     ram_raddr,
    input  logic [CHAR_W-1:0] ram_rdata
);

    wrs_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          per_reg, per_next;
    logic          com_reg, com_next;
    logic          last_reg, last_next;

    logic              ovalid_reg;
    logic [CHAR_W-1:0] ochar_reg;
    logic              olast_reg;
    logic              odone_reg;
    logic              oovf_reg;

    logic              emit_req;
    logic [CHAR_W-1:0] emit_char;
    logic              emit_last;
    logic              emit_done;
    logic              emit_go;
    logic              accept;
    logic [CW-1:0]     cnt_dec;
    logic              cnt_one;
    logic              not_full;

    assign cnt_dec   = count_reg - CW'(1);
    assign cnt_one   = (count_reg == CW'(1));
    assign not_full  = (count_reg < CW'(DEPTH));
    assign ram_raddr = cnt_dec[AW-1:0];
    assign ram_waddr = count_reg[AW-1:0];
    assign ram_wdata = char_ch.in_char;

    assign accept  = char_ch.valid && char_ch.ready;
    assign emit_go = emit_req && (!ovalid_reg || rev_ch.ready);

    // Output decode
    always_comb
    begin
        char_ch.ready = 1'b0;
        ram_we        = 1'b0;
        emit_req      = 1'b0;
        emit_char     = ram_rdata;
        emit_last     = 1'b0;
        emit_done     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                char_ch.ready = 1'b1;
                ram_we = char_ch.valid && (char_ch.in_char != CH_SPACE) && not_full;
            end
            ST_WORD_EMIT, ST_FL_EMIT:
            begin
                emit_req = 1'b1;
            end
            ST_TAIL:
            begin
                emit_req = 1'b1;
                if (com_reg)
                begin
                    emit_char = CH_COMMA;
                end
                else if (per_reg)
                begin
                    emit_char = CH_PERIOD;
                end
                else
                begin
                    emit_char = CH_SPACE;
                    emit_last = !last_reg;
                end
            end
            ST_CLOSE:
            begin
                emit_req  = 1'b1;
                emit_char = CH_PERIOD;
                emit_last = 1'b1;
                emit_done = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Next state; every *_RD state waits for the top-of-stack read
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        per_next   = per_reg;
        com_next   = com_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = char_ch.line_end;
                    if (char_ch.in_char != CH_SPACE)
                    begin
                        if (not_full)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        state_next = char_ch.line_end ? ST_FL_RD : ST_IDLE;
                    end
                    else
                    begin
                        per_next   = 1'b0;
                        com_next   = 1'b0;
                        state_next = (count_reg == '0) ? ST_TAIL : ST_SP_RD;
                    end
                end
            end
            ST_SP_RD:
            begin
                state_next = ST_SP_PER;
            end
            ST_SP_PER:
            begin
                if (ram_rdata == CH_PERIOD)
                begin
                    per_next   = 1'b1;
                    count_next = cnt_dec;
                    state_next = cnt_one ? ST_TAIL : ST_SP_COM_RD;
                end
                else
                begin
                    state_next = ST_SP_COM;
                end
            end
            ST_SP_COM_RD:
            begin
                state_next = ST_SP_COM;
            end
            ST_SP_COM:
            begin
                if (ram_rdata == CH_COMMA)
                begin
                    com_next   = 1'b1;
                    count_next = cnt_dec;
                    state_next = cnt_one ? ST_TAIL : ST_WORD_RD;
                end
                else
                begin
                    state_next = ST_WORD_EMIT;
                end
            end
            ST_WORD_RD:
            begin
                state_next = ST_WORD_EMIT;
            end
            ST_WORD_EMIT:
            begin
                if (emit_go)
                begin
                    count_next = cnt_dec;
                    state_next = cnt_one ? ST_TAIL : ST_WORD_RD;
                end
            end
            ST_TAIL:
            begin
                if (emit_go)
                begin
                    if (com_reg)
                    begin
                        com_next = 1'b0;
                    end
                    else if (per_reg)
                    begin
                        per_next = 1'b0;
                    end
                    else
                    begin
                        state_next = last_reg ? ST_FL_RD : ST_IDLE;
                    end
                end
            end
            ST_FL_RD:
            begin
                state_next = (count_reg == '0) ? ST_CLOSE : ST_FL_CHK;
            end
            ST_FL_CHK:
            begin
                // one period on top is dropped, the entry below it goes out as is
                if (ram_rdata == CH_PERIOD)
                begin
                    count_next = cnt_dec;
                    state_next = cnt_one ? ST_CLOSE : ST_FL_EMIT_RD;
                end
                else
                begin
                    state_next = ST_FL_EMIT;
                end
            end
            ST_FL_EMIT_RD:
            begin
                state_next = ST_FL_EMIT;
            end
            ST_FL_EMIT:
            begin
                if (emit_go)
                begin
                    count_next = cnt_dec;
                    state_next = ST_FL_RD;
                end
            end
            ST_CLOSE:
            begin
                if (emit_go)
                begin
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            per_reg    <= 1'b0;
            com_reg    <= 1'b0;
            last_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            per_reg   <= per_next;
            com_reg   <= com_next;
            last_reg  <= last_next;
            if (emit_go)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (rev_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            ochar_reg <= emit_char;
            olast_reg <= emit_last;
            odone_reg <= emit_done;
            oovf_reg  <= ovf_reg;
        end
    end

    assign rev_ch.valid     = ovalid_reg;
    assign rev_ch.out_char  = ochar_reg;
    assign rev_ch.run_last  = olast_reg;
    assign rev_ch.line_done = odone_reg;
    assign rev_ch.overflow  = oovf_reg;

endmodule

@@ rtl/wrs_checker.sv @@
// Port-level checks for word_reverser_stack, attached by bind.
// Depends on wrs_pkg and the top level.
module wrs_checker import wrs_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [CHAR_W-1:0] in_char,
    input logic              line_end,
    input logic              out_valid,
    input logic              out_ready,
    input logic [CHAR_W-1:0] out_char,
    input logic              run_last,
    input logic              line_done,
    input logic              overflow
);

    // a transfer that is stalled stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    // a stalled transfer keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({out_char, run_last, line_done, overflow}))
        else $error("output payload changed while stalled");

    // the closing period is always the last byte of its item
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_done |-> run_last && (out_char == CH_PERIOD))
        else $error("line_done without run_last or period");

    // a space always produces output, so the block is busy right after it
    a_space_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_char == CH_SPACE) |=> !in_ready)
        else $error("ready right after a space transfer");

    // a plain character mid-line needs no work
    a_push_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_char != CH_SPACE) && !line_end |=> in_ready)
        else $error("not ready after a plain push");

endmodule

bind word_reverser_stack wrs_checker u_wrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (char_ch.valid),
    .in_ready  (char_ch.ready),
    .in_char   (char_ch.in_char),
    .line_end  (char_ch.line_end),
    .out_valid (rev_ch.valid),
    .out_ready (rev_ch.ready),
    .out_char  (rev_ch.out_char),
    .run_last  (rev_ch.run_last),
    .line_done (rev_ch.line_done),
    .overflow  (rev_ch.overflow)
);
